>>> hw/rtl/sphere_grow_placement_defines.svh
// Assertion macros for the sphere placement block
`ifndef SPHERE_GROW_PLACEMENT_DEFINES_SVH
`define SPHERE_GROW_PLACEMENT_DEFINES_SVH

// Clocked implication, disabled during reset
`define SGP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Clocked next-cycle implication, disabled during reset
`define SGP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/sgp_pkg.sv
// Shared types and constants of the sphere placement block
package sgp_pkg;

  localparam int unsigned TableDepth = 1024;
  localparam int unsigned IdxW       = $clog2(TableDepth);
  localparam int unsigned CntW       = $clog2(TableDepth + 1);
  localparam int unsigned CoordW     = 16;
  localparam int unsigned TriesW     = 17;
  localparam int unsigned DistW      = 34;

  typedef struct packed {
    logic [CoordW-1:0] r;
    logic [CoordW-1:0] z;
    logic [CoordW-1:0] y;
    logic [CoordW-1:0] x;
  } entry_t;

  typedef enum logic [1:0] {
    ST_PLACED   = 2'd0,
    ST_REJECTED = 2'd1,
    ST_GAVE_UP  = 2'd2,
    ST_HALTED   = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    REG_BOX_X      = 3'd0,
    REG_BOX_Y      = 3'd1,
    REG_BOX_Z      = 3'd2,
    REG_RADIUS_MIN = 3'd3,
    REG_RADIUS_MAX = 3'd4,
    REG_RADIUS_STP = 3'd5,
    REG_MAX_TRIES  = 3'd6
  } reg_idx_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_GROW,
    S_RD,
    S_WAIT,
    S_CMP,
    S_DONE
  } state_e;

endpackage

>>> hw/rtl/sgp_table.sv
// Sphere table: one write port, one registered read port
module sgp_table
  import sgp_pkg::*;
(
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [IdxW-1:0] waddr_i,
  input  entry_t          wdata_i,
  input  logic [IdxW-1:0] raddr_i,
  output entry_t          rdata_o
);

  entry_t mem_q [TableDepth];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/sgp_dist.sv
// Distance pipeline: squared centre distance and squared radius sum, two stages
module sgp_dist
  import sgp_pkg::*;
(
  input  logic              clk_i,
  input  entry_t            entry_i,
  input  logic [CoordW-1:0] cx_i,
  input  logic [CoordW-1:0] cy_i,
  input  logic [CoordW-1:0] cz_i,
  input  logic [CoordW-1:0] t_i,
  output logic [DistW-1:0]  dist_o,
  output logic [DistW-1:0]  rs2_o
);

  logic [CoordW-1:0]   dx, dy, dz;
  logic [2*CoordW-1:0] sqx_q, sqy_q, sqz_q;
  logic [DistW-1:0]    dist_q;
  logic [CoordW:0]     rs_q;
  logic [DistW-1:0]    rs2_q;

  // absolute differences
  assign dx = (entry_i.x > cx_i) ? entry_i.x - cx_i : cx_i - entry_i.x;
  assign dy = (entry_i.y > cy_i) ? entry_i.y - cy_i : cy_i - entry_i.y;
  assign dz = (entry_i.z > cz_i) ? entry_i.z - cz_i : cz_i - entry_i.z;

  always_ff @(posedge clk_i) begin
    sqx_q  <= (2*CoordW)'(dx) * (2*CoordW)'(dx);
    sqy_q  <= (2*CoordW)'(dy) * (2*CoordW)'(dy);
    sqz_q  <= (2*CoordW)'(dz) * (2*CoordW)'(dz);
    dist_q <= DistW'(sqx_q) + DistW'(sqy_q) + DistW'(sqz_q);
    rs_q   <= {1'b0, entry_i.r} + {1'b0, t_i};
    rs2_q  <= DistW'(rs_q) * DistW'(rs_q);
  end

  assign dist_o = dist_q;
  assign rs2_o  = rs2_q;

endmodule

>>> hw/rtl/sphere_grow_placement.sv
// Top level of the sphere placement block: control, registers, stream ports
// Flow: when halted the answer comes straight from idle; else the radius grows by steps,
//   then each stored sphere is read and compared, and a hit shrinks the radius or rejects.
// Throughput: one transaction at a time; the next is taken once the result is
//   registered, even while the result still waits on the output.
// Reset: asynchronous, active low; clears count, reject run, halt flag and
//   registers to their defaults. The table holds nothing valid until written.
module sphere_grow_placement
  import sgp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // cand_x, cand_y, cand_z
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // status, grown_radius, sphere_index, zero pad
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [16:0] cfg_data_i
);

  `include "sphere_grow_placement_defines.svh"

  // configuration registers
  logic [CoordW-1:0] box_x_q, box_y_q, box_z_q, rmin_q, rmax_q, rstep_q;
  logic [TriesW-1:0] tries_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_x_q <= 16'd10240;
      box_y_q <= 16'd10240;
      box_z_q <= 16'd10240;
      rmin_q  <= 16'd205;
      rmax_q  <= 16'd2048;
      rstep_q <= 16'd10;
      tries_q <= 17'd100000;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_BOX_X:      box_x_q <= cfg_data_i[CoordW-1:0];
        REG_BOX_Y:      box_y_q <= cfg_data_i[CoordW-1:0];
        REG_BOX_Z:      box_z_q <= cfg_data_i[CoordW-1:0];
        REG_RADIUS_MIN: rmin_q  <= cfg_data_i[CoordW-1:0];
        REG_RADIUS_MAX: rmax_q  <= cfg_data_i[CoordW-1:0];
        REG_RADIUS_STP: rstep_q <= cfg_data_i[CoordW-1:0];
        REG_MAX_TRIES:  tries_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // control state
  state_e            state_q, state_d;
  logic [CntW-1:0]   count_q, count_d, j_q, j_d;
  logic [TriesW-1:0] run_q, run_d;
  logic              halted_q, halted_d;
  logic              wait_q, wait_d;
  status_e           st_q, st_d;
  logic [CoordW-1:0] cx_q, cy_q, cz_q, t_q, t_d;
  logic              ld_cand;
  logic              out_ld;
  logic [31:0]       out_d;
  logic              mvalid_q, mvalid_d;
  logic [31:0]       mdata_q;

  logic              we;
  entry_t            wentry, rentry;
  logic [DistW-1:0]  dist_sq, rs2;

  sgp_table u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (count_q[IdxW-1:0]),
    .wdata_i (wentry),
    .raddr_i (j_q[IdxW-1:0]),
    .rdata_o (rentry)
  );

  sgp_dist u_dist (
    .clk_i   (clk_i),
    .entry_i (rentry),
    .cx_i    (cx_q),
    .cy_i    (cy_q),
    .cz_i    (cz_q),
    .t_i     (t_q),
    .dist_o  (dist_sq),
    .rs2_o   (rs2)
  );

  assign wentry = '{r: t_q, z: cz_q, y: cy_q, x: cx_q};

  // next growth step and wall checks
  logic [CoordW:0] nt;
  logic            grow_ok;
  assign nt = {1'b0, t_q} + {1'b0, rstep_q};
  assign grow_ok = (rstep_q != '0) && (nt < {1'b0, rmax_q})
    && ({2'b0, cx_q} + {1'b0, nt} <= {2'b0, box_x_q}) && ({1'b0, cx_q} >= nt)
    && ({2'b0, cy_q} + {1'b0, nt} <= {2'b0, box_y_q}) && ({1'b0, cy_q} >= nt)
    && ({2'b0, cz_q} + {1'b0, nt} <= {2'b0, box_z_q}) && ({1'b0, cz_q} >= nt);

  logic [TriesW-1:0] run_inc;
  assign run_inc = (run_q == {TriesW{1'b1}}) ? run_q : run_q + 1'b1;

  assign s_axis_tready = (state_q == S_IDLE);

  // next state and outputs
  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    j_d      = j_q;
    run_d    = run_q;
    halted_d = halted_q;
    wait_d   = wait_q;
    st_d     = st_q;
    t_d      = t_q;
    ld_cand  = 1'b0;
    we       = 1'b0;
    out_ld   = 1'b0;
    out_d    = '0;
    mvalid_d = mvalid_q;
    if (mvalid_q && m_axis_tready) begin
      mvalid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          ld_cand = 1'b1;
          t_d     = rmin_q;
          j_d     = '0;
          if (halted_q) begin
            st_d    = ST_HALTED;
            state_d = S_DONE;
          end else begin
            state_d = S_GROW;
          end
        end
      end
      S_GROW: begin
        if (grow_ok) begin
          t_d = nt[CoordW-1:0];
        end else if (count_q == '0) begin
          st_d    = ST_PLACED;
          state_d = S_DONE;
        end else begin
          state_d = S_RD;
        end
      end
      S_RD: begin
        wait_d  = 1'b1;
        state_d = S_WAIT;
      end
      S_WAIT: begin
        wait_d = 1'b0;
        if (!wait_q) begin
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        if (dist_sq < rs2) begin
          if (t_q == rmin_q) begin
            st_d    = (run_inc >= tries_q) ? ST_GAVE_UP : ST_REJECTED;
            state_d = S_DONE;
          end else begin
            // smaller radius must pass through the radius stages before the compare
            t_d     = t_q - rstep_q;
            wait_d  = 1'b1;
            state_d = S_WAIT;
          end
        end else if (j_q + 1'b1 == count_q) begin
          st_d    = ST_PLACED;
          state_d = S_DONE;
        end else begin
          j_d     = j_q + 1'b1;
          state_d = S_RD;
        end
      end
      S_DONE: begin
        if (!mvalid_q || m_axis_tready) begin
          out_ld   = 1'b1;
          mvalid_d = 1'b1;
          state_d  = S_IDLE;
          case (st_q)
            ST_PLACED: begin
              we       = 1'b1;
              out_d    = {4'b0, 10'(count_q), t_q, ST_PLACED};
              count_d  = count_q + 1'b1;
              run_d    = '0;
              halted_d = (count_q + 1'b1 == CntW'(TableDepth));
            end
            ST_REJECTED: begin
              out_d = {30'b0, ST_REJECTED};
              run_d = run_inc;
            end
            ST_GAVE_UP: begin
              out_d    = {30'b0, ST_GAVE_UP};
              run_d    = run_inc;
              halted_d = 1'b1;
            end
            default: begin
              out_d = {30'b0, ST_HALTED};
            end
          endcase
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      j_q      <= '0;
      run_q    <= '0;
      halted_q <= 1'b0;
      wait_q   <= 1'b0;
      st_q     <= ST_PLACED;
      mvalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      j_q      <= j_d;
      run_q    <= run_d;
      halted_q <= halted_d;
      wait_q   <= wait_d;
      st_q     <= st_d;
      mvalid_q <= mvalid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    t_q <= t_d;
    if (ld_cand) begin
      cx_q <= s_axis_tdata[15:0];
      cy_q <= s_axis_tdata[31:16];
      cz_q <= s_axis_tdata[47:32];
    end
    if (out_ld) begin
      mdata_q <= out_d;
    end
  end

  assign m_axis_tvalid = mvalid_q;
  assign m_axis_tdata  = mdata_q;

  `SGP_ASSERT_NXT(a_halt_sticky, halted_q, halted_q, "halt flag cleared without reset")
  `SGP_ASSERT_IMP(a_count_range, 1'b1, count_q <= CntW'(TableDepth), "sphere count overflow")
  `SGP_ASSERT_IMP(a_cmp_radius, state_q == S_CMP, t_q >= rmin_q, "radius fell below minimum")
  `SGP_ASSERT_IMP(a_scan_bound, state_q == S_CMP, j_q < count_q, "scan beyond stored spheres")

endmodule

>>> verif/sphere_grow_placement_tb.sv
// Testbench of the sphere placement block: directed and random candidates checked
// against a predictor of the placement table
`timescale 1ns / 100ps

module sphere_grow_placement_tb;
  import sgp_pkg::*;

  localparam int unsigned StallLimit = 400000;

  typedef struct {
    status_e    st;
    bit [15:0]  radius;
    bit [9:0]   slot;
  } placement_t;

  // DUT ports
  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;   // cand_x, cand_y, cand_z
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // status, grown_radius, sphere_index, zero pad
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [16:0] cfg_data_i = '0;

  // Predictor state
  bit [15:0]   tbl_x [TableDepth];
  bit [15:0]   tbl_y [TableDepth];
  bit [15:0]   tbl_z [TableDepth];
  bit [15:0]   tbl_r [TableDepth];
  int unsigned n_spheres;
  int unsigned reject_run;
  bit          halted;
  int unsigned box [3];
  int unsigned rad_min, rad_max, rad_step, tries_max;

  placement_t  placements_q [$];
  int unsigned n_errors;
  int unsigned idle_cycles;
  int unsigned hold_off;   // receiver hold-off, counted down by the sink
  bit          quiet;      // no idling on either side

  sphere_grow_placement u_top (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  always #2 clk_i = ~clk_i;

  function automatic int unsigned pick_gap();
    int unsigned p;
    if (quiet) return 0;
    p = $urandom_range(99);
    if (p < 60) return 0;
    if (p < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  function automatic longint unsigned sq_dist(bit [15:0] a, bit [15:0] b);
    longint unsigned d;
    d = (a > b) ? longint'(a - b) : longint'(b - a);
    return d * d;
  endfunction

  // True if a sphere of radius r at (x,y,z) hits any stored sphere
  function automatic bit hits_table(int unsigned r, bit [15:0] x, bit [15:0] y, bit [15:0] z);
    longint unsigned d2, rs;
    for (int unsigned j = 0; j < n_spheres; j++) begin
      d2 = sq_dist(tbl_x[j], x) + sq_dist(tbl_y[j], y) + sq_dist(tbl_z[j], z);
      rs = longint'(tbl_r[j]) + longint'(r);
      if (d2 < rs * rs) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic bit in_box(bit [15:0] c, int unsigned t, int unsigned b);
    return (c + t <= b) && (c >= t);
  endfunction

  // Works out the placement outcome of one candidate and updates the table
  function automatic placement_t place_candidate(bit [15:0] x, bit [15:0] y, bit [15:0] z);
    placement_t  res;
    int unsigned r, t;
    res = '{ST_HALTED, 16'd0, 10'd0};
    if (halted || n_spheres >= TableDepth) begin
      halted = 1'b1;
      return res;
    end
    r = rad_min;
    if (hits_table(r, x, y, z)) begin
      if (reject_run < 32'h1FFFF) reject_run++;
      if (reject_run >= tries_max) begin
        halted = 1'b1;
        res.st = ST_GAVE_UP;
      end else begin
        res.st = ST_REJECTED;
      end
      return res;
    end
    if (rad_step != 0) begin
      while (r + rad_step < rad_max) begin
        t = r + rad_step;
        if (!in_box(x, t, box[0]) || !in_box(y, t, box[1]) || !in_box(z, t, box[2])) break;
        if (hits_table(t, x, y, z)) break;
        r = t;
      end
    end
    tbl_x[n_spheres] = x;
    tbl_y[n_spheres] = y;
    tbl_z[n_spheres] = z;
    tbl_r[n_spheres] = r[15:0];
    res = '{ST_PLACED, r[15:0], n_spheres[9:0]};
    n_spheres++;
    reject_run = 0;
    if (n_spheres >= TableDepth) halted = 1'b1;
    return res;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    n_errors++;
  endtask

  // Sends one candidate and records its expected outcome on acceptance
  task automatic send_cand(bit [15:0] x, bit [15:0] y, bit [15:0] z);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {z, y, x};
    do @(posedge clk_i); while (!s_axis_tready);
    placements_q.push_back(place_candidate(x, y, z));
  endtask

  task automatic drain();
    @(posedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (placements_q.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, int unsigned val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val[16:0];
    case (idx)
      REG_BOX_X:      box[0]    = val & 16'hFFFF;
      REG_BOX_Y:      box[1]    = val & 16'hFFFF;
      REG_BOX_Z:      box[2]    = val & 16'hFFFF;
      REG_RADIUS_MIN: rad_min   = val & 16'hFFFF;
      REG_RADIUS_MAX: rad_max   = val & 16'hFFFF;
      REG_RADIUS_STP: rad_step  = val & 16'hFFFF;
      REG_MAX_TRIES:  tries_max = val & 17'h1FFFF;
      default: ;
    endcase
  endtask

  task automatic write_done();
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Reset settings: centered growth, neighbors limiting growth, corners, bit extremes
  task automatic test_defaults();
    send_cand(16'd5120, 16'd5120, 16'd5120);
    send_cand(16'd5120, 16'd5120, 16'd5120);
    send_cand(16'd5120, 16'd5120, 16'd9000);
    send_cand(16'd0, 16'd0, 16'd0);
    send_cand(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_cand(16'd5120, 16'd7300, 16'd5120);
    send_cand(16'd5400, 16'd5120, 16'd5120);
    send_cand(16'hAAAA, 16'h5555, 16'h0F0F);
    drain();
  endtask

  // Register extremes: zero and full box, zero step, huge step, zero and full radius
  task automatic test_reg_extremes();
    write_reg(REG_BOX_X, 0);
    write_reg(REG_BOX_Y, 65535);
    write_reg(REG_BOX_Z, 65535);
    write_reg(REG_RADIUS_STP, 0);
    write_reg(REG_MAX_TRIES, 131071);
    write_done();
    send_cand(16'd30000, 16'd30000, 16'd100);
    send_cand(16'd5120, 16'd5120, 16'd5120);
    drain();
    write_reg(REG_BOX_X, 65535);
    write_reg(REG_RADIUS_STP, 65535);
    write_reg(REG_RADIUS_MAX, 65535);
    write_reg(REG_RADIUS_MIN, 0);
    write_done();
    send_cand(16'd40000, 16'd20000, 16'd20000);
    send_cand(16'd40000, 16'd20000, 16'd20000);
    drain();
    // Growth capped by the radius limit, and a zero limit
    write_reg(REG_RADIUS_MIN, 100);
    write_reg(REG_RADIUS_STP, 50);
    write_reg(REG_RADIUS_MAX, 260);
    write_done();
    send_cand(16'd50000, 16'd50000, 16'd50000);
    drain();
    write_reg(REG_RADIUS_MAX, 0);
    write_done();
    send_cand(16'd60000, 16'd10000, 16'd50000);
    drain();
    // Full minimum radius: a candidate on a stored center, with the widest distance
    write_reg(REG_RADIUS_MIN, 65535);
    write_done();
    send_cand(tbl_x[0], tbl_y[0], tbl_z[0]);
    send_cand(tbl_x[1], tbl_y[1], tbl_z[1]);
    drain();
  endtask

  // Random settings and candidates; the first phase holds the receiver off
  task automatic test_random(int unsigned n_phases, int unsigned per_phase);
    int unsigned b, lo, p;
    bit [15:0]   c [3];
    for (int unsigned ph = 0; ph < n_phases; ph++) begin
      b = ($urandom_range(3) == 0) ? 65535 : $urandom_range(12000, 3000);
      write_reg(REG_BOX_X, b);
      write_reg(REG_BOX_Y, $urandom_range(3) == 0 ? 65535 : b);
      write_reg(REG_BOX_Z, b);
      write_reg(REG_RADIUS_MIN, $urandom_range(700, 80));
      write_reg(REG_RADIUS_STP, $urandom_range(300, 20));
      write_reg(REG_RADIUS_MAX, rad_min + rad_step * $urandom_range(5));
      write_reg(REG_MAX_TRIES, $urandom_range(131071, 2000));
      write_done();
      quiet = (ph == 1);
      if (ph == 0) hold_off = 600;
      lo = b / 4;
      for (int unsigned i = 0; i < per_phase; i++) begin
        p = $urandom_range(99);
        for (int k = 0; k < 3; k++) begin
          if (p < 70) c[k] = 16'($urandom_range(lo + lo, lo));
          else c[k] = 16'($urandom_range(16'hFFFF));
        end
        if (p >= 95 && n_spheres > 0) begin
          lo = $urandom_range(n_spheres - 1);
          c = '{tbl_x[lo], tbl_y[lo], tbl_z[lo]};
          lo = b / 4;
        end
        send_cand(c[0], c[1], c[2]);
      end
      drain();
    end
    quiet = 1'b0;
  endtask

  // Rejections up to the try limit, then the halted answer
  task automatic test_give_up();
    write_reg(REG_RADIUS_MIN, 300);
    write_reg(REG_MAX_TRIES, 2);
    write_done();
    send_cand(tbl_x[0], tbl_y[0], tbl_z[0]);
    send_cand(tbl_x[0], tbl_y[0], tbl_z[0]);
    send_cand(16'd1000, 16'd60000, 16'd30000);
    send_cand(16'hFFFF, 16'd0, 16'hFFFF);
    send_cand(tbl_x[2], tbl_y[2], tbl_z[2]);
    drain();
  endtask

  // Result check and receiver stalls
  always @(posedge clk_i) begin
    placement_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (placements_q.size() == 0) begin
          report_mismatch("unexpected result, status", 32'(m_axis_tdata[1:0]), 0);
        end else begin
          want = placements_q.pop_front();
          if (m_axis_tdata[1:0] != want.st)
            report_mismatch("status", 32'(m_axis_tdata[1:0]), 32'(want.st));
          if (m_axis_tdata[17:2] != want.radius)
            report_mismatch("grown_radius", 32'(m_axis_tdata[17:2]), 32'(want.radius));
          if (m_axis_tdata[27:18] != want.slot)
            report_mismatch("sphere_index", 32'(m_axis_tdata[27:18]), 32'(want.slot));
        end
      end
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= (pick_gap() == 0);
      end
    end
  end

  // Watchdog on cycles with no transaction on either side
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    n_spheres = 0; reject_run = 0; halted = 1'b0;
    box = '{10240, 10240, 10240};
    rad_min = 205; rad_max = 2048; rad_step = 10; tries_max = 100000;
    n_errors = 0; idle_cycles = 0; hold_off = 0; quiet = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    test_defaults();
    test_reg_extremes();
    test_random(5, 52);
    test_give_up();
    if (n_errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
